[hw/rtl/tsb_pkg.sv]
package tsb_pkg;

    // Stored pixel: color [1:0], attribute [3:2], sprite flag [4]
    localparam int PIX_W = 5;
    typedef logic [PIX_W-1:0] pixel_t;

    localparam int PIX_SPRITE_BIT = 4;

    // Stream and register port widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Opcodes carried in s_tuser
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_DRAW = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Register byte addresses
    localparam logic [PADDR_W-1:0] ADDR_VIEW_W = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_VIEW_H = 3'd4;

    localparam logic [8:0] VIEW_W_RESET = 9'd256;
    localparam logic [8:0] VIEW_H_RESET = 9'd240;

endpackage

[hw/rtl/tsb_fb_ram.sv]
module tsb_fb_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  tsb_pkg::pixel_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output tsb_pkg::pixel_t rd_data
);
    import tsb_pkg::*;

    pixel_t mem [DEPTH];
    pixel_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/tile_sprite_blitter_unit.sv]
// Channel  | Dir | Handshake                | Payload
// ---------+-----+--------------------------+-----------------------------------------
// s_       | in  | s_tvalid / s_tready      | s_tuser opcode, s_tdata draw/load/read args
// m_       | out | m_tvalid / m_tready      | m_tuser read_valid, m_tdata stored pixel
// apb      | in  | psel, penable, pwrite    | view_width @0x0, view_height @0x4
//
// A load or an unused opcode is answered when its transfer is taken, a read
// issues a framebuffer read and answers from S_RDATA, and a draw takes the
// transfer, walks the texels in S_DRAW on the single framebuffer read port,
// then writes the last texel back in S_FLUSH before it answers.
// Reset: after aresetn the framebuffer is swept to zero, one pixel a cycle,
// with s_tready low; APB stays live.
// Stalls: one item at a time; a result waits in the output register and the
// next item is taken as soon as that register is free or being drained.
module tile_sprite_blitter_unit #(
    parameter int TILE_SIZE     = 8,
    parameter int FB_MAX_WIDTH  = 256,
    parameter int FB_MAX_HEIGHT = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [2:0] row_index, [18:3] row_colors, [27:19] pos_x, [36:28] pos_y,
    // [38:37] palette_attr, [39] is_sprite, [40] flip_h, [41] flip_v
    input  logic [tsb_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] opcode
    input  logic [tsb_pkg::S_TUSER_W-1:0] s_tuser,

    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] pixel_color, [3:2] pixel_attr, [4] pixel_sprite
    output logic [tsb_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] read_valid
    output logic                          m_tuser,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsb_pkg::PADDR_W-1:0]   paddr,
    input  logic [tsb_pkg::PDATA_W-1:0]   pwdata,
    output logic [tsb_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import tsb_pkg::*;

    localparam int DEPTH = FB_MAX_WIDTH * FB_MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int TB    = $clog2(TILE_SIZE);
    localparam int TW    = 2 * TILE_SIZE;
    localparam int MAXD  = (FB_MAX_WIDTH > FB_MAX_HEIGHT) ? FB_MAX_WIDTH : FB_MAX_HEIGHT;
    localparam int CB    = $clog2(MAXD + 1);
    // unsigned coordinate / view width, then one sign bit on top
    localparam int EW    = (CB > 9) ? CB : 9;
    localparam int SW    = EW + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DRAW,
        S_FLUSH,
        S_RDATA
    } state_t;

    state_t             state_reg;
    logic [AW-1:0]      clr_addr_reg;

    logic [8:0]         view_w_reg;
    logic [8:0]         view_h_reg;

    logic [2*TILE_SIZE-1:0] tile_reg [TILE_SIZE];

    // latched draw arguments
    logic signed [SW-1:0] px_reg;
    logic signed [SW-1:0] py_reg;
    logic [1:0]         attr_reg;
    logic               sprite_reg;
    logic               fh_reg;
    logic               fv_reg;
    logic [TB-1:0]      row_reg;
    logic [TB-1:0]      col_reg;

    // write-back stage of the draw pipeline
    logic               wr_en_reg;
    logic [AW-1:0]      wr_addr_reg;
    pixel_t             wr_data_reg;
    logic               wr_keep_reg;

    logic               rd_hit_reg;

    // output register
    logic               m_valid_reg;
    logic               m_hit_reg;
    pixel_t             m_pix_reg;

    // input fields
    logic [2:0]         in_row;
    logic [15:0]        in_colors;
    logic [8:0]         in_px;
    logic [8:0]         in_py;
    logic [1:0]         in_attr;
    logic               in_sprite;
    logic               in_fh;
    logic               in_fv;
    logic [1:0]         in_op;

    assign in_row    = s_tdata[2:0];
    assign in_colors = s_tdata[18:3];
    assign in_px     = s_tdata[27:19];
    assign in_py     = s_tdata[36:28];
    assign in_attr   = s_tdata[38:37];
    assign in_sprite = s_tdata[39];
    assign in_fh     = s_tdata[40];
    assign in_fv     = s_tdata[41];
    assign in_op     = s_tuser;

    // effective view, saturated to the framebuffer size
    logic [EW-1:0] eff_w;
    logic [EW-1:0] eff_h;

    assign eff_w = (EW'(view_w_reg) > EW'(FB_MAX_WIDTH)) ? EW'(FB_MAX_WIDTH) : EW'(view_w_reg);
    assign eff_h = (EW'(view_h_reg) > EW'(FB_MAX_HEIGHT)) ? EW'(FB_MAX_HEIGHT) : EW'(view_h_reg);

    logic slot_free;
    logic s_accept;

    assign slot_free = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && slot_free;
    assign s_accept  = s_tvalid && s_tready;

    // a result enters the output register at this edge
    logic m_load;

    assign m_load = (state_reg == S_IDLE)
                    ? (s_accept && (in_op != OP_DRAW) && (in_op != OP_READ))
                    : (((state_reg == S_FLUSH) || (state_reg == S_RDATA)) && slot_free);

    // read item address and hit
    logic signed [SW-1:0] rd_x;
    logic signed [SW-1:0] rd_y;
    logic               rd_item_hit;
    logic [AW-1:0]      rd_item_addr;

    assign rd_x = {{(SW-9){in_px[8]}}, in_px};
    assign rd_y = {{(SW-9){in_py[8]}}, in_py};
    assign rd_item_hit = !rd_x[SW-1] && !rd_y[SW-1]
                         && (rd_x[EW-1:0] < eff_w) && (rd_y[EW-1:0] < eff_h);
    assign rd_item_addr = AW'(rd_y[EW-1:0]) * AW'(FB_MAX_WIDTH) + AW'(rd_x[EW-1:0]);

    // current texel of a draw: screen position is tile position plus counter
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
    logic               tex_vis;
    logic [TB-1:0]      tex_r;
    logic [TB-1:0]      tex_c;
    logic [1:0]         texel;
    logic [AW-1:0]      draw_addr;
    logic               draw_last;

    assign sx = px_reg + $signed({{(SW-TB){1'b0}}, col_reg});
    assign sy = py_reg + $signed({{(SW-TB){1'b0}}, row_reg});
    assign tex_vis = !sx[SW-1] && !sy[SW-1] && (sx[EW-1:0] < eff_w) && (sy[EW-1:0] < eff_h);
    assign tex_r = fv_reg ? (TB'(TILE_SIZE - 1) - row_reg) : row_reg;
    assign tex_c = fh_reg ? (TB'(TILE_SIZE - 1) - col_reg) : col_reg;
    assign texel = tile_reg[tex_r][{tex_c, 1'b0} +: 2];
    assign draw_addr = AW'(sy[EW-1:0]) * AW'(FB_MAX_WIDTH) + AW'(sx[EW-1:0]);
    assign draw_last = (row_reg == TB'(TILE_SIZE - 1)) && (col_reg == TB'(TILE_SIZE - 1));

    // framebuffer port muxing
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    pixel_t             ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    pixel_t             ram_rdata;

    always_comb begin
        if (state_reg == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = wr_en_reg;
            ram_waddr = wr_addr_reg;
            // transparent sprite texel: keep pixel, set sprite flag
            ram_wdata = wr_keep_reg ? (ram_rdata | pixel_t'(1 << PIX_SPRITE_BIT))
                                    : wr_data_reg;
        end
    end

    always_comb begin
        if (state_reg == S_DRAW) begin
            ram_re    = tex_vis;
            ram_raddr = draw_addr;
        end else begin
            ram_re    = s_accept && (in_op == OP_READ) && rd_item_hit;
            ram_raddr = rd_item_addr;
        end
    end

    tsb_fb_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_fb_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // control, draw pipeline and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            wr_en_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
            row_reg      <= '0;
            col_reg      <= '0;
            rd_hit_reg   <= 1'b0;
            for (int i = 0; i < TILE_SIZE; i++) begin
                tile_reg[i] <= '0;
            end
        end else begin
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            wr_en_reg <= (state_reg == S_DRAW) && tex_vis;

            unique case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == AW'(DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_accept) begin
                        case (in_op)
                            OP_LOAD: begin
                                tile_reg[TB'(in_row)] <= TW'(in_colors);
                                m_hit_reg   <= 1'b0;
                                m_pix_reg   <= '0;
                            end
                            OP_DRAW: begin
                                px_reg     <= {{(SW-9){in_px[8]}}, in_px};
                                py_reg     <= {{(SW-9){in_py[8]}}, in_py};
                                attr_reg   <= in_attr;
                                sprite_reg <= in_sprite;
                                fh_reg     <= in_sprite && in_fh;
                                fv_reg     <= in_sprite && in_fv;
                                row_reg    <= '0;
                                col_reg    <= '0;
                                state_reg  <= S_DRAW;
                            end
                            OP_READ: begin
                                rd_hit_reg <= rd_item_hit;
                                state_reg  <= S_RDATA;
                            end
                            default: begin
                                m_hit_reg   <= 1'b0;
                                m_pix_reg   <= '0;
                            end
                        endcase
                    end
                end
                S_DRAW: begin
                    wr_addr_reg <= draw_addr;
                    wr_keep_reg <= sprite_reg && (texel == 2'd0);
                    wr_data_reg <= {sprite_reg, attr_reg, texel};
                    if (col_reg == TB'(TILE_SIZE - 1)) begin
                        col_reg <= '0;
                        row_reg <= row_reg + 1'b1;
                    end else begin
                        col_reg <= col_reg + 1'b1;
                    end
                    if (draw_last) begin
                        state_reg <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    // last texel is written at this edge
                    if (slot_free) begin
                        m_hit_reg   <= 1'b0;
                        m_pix_reg   <= '0;
                        state_reg   <= S_IDLE;
                    end
                end
                S_RDATA: begin
                    if (slot_free) begin
                        m_hit_reg   <= rd_hit_reg;
                        m_pix_reg   <= rd_hit_reg ? ram_rdata : '0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_hit_reg;
    assign m_tdata  = {{(M_TDATA_W-PIX_W){1'b0}}, m_pix_reg};

    // configuration registers
    logic cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            view_w_reg <= VIEW_W_RESET;
            view_h_reg <= VIEW_H_RESET;
        end else if (cfg_wr) begin
            unique case (paddr)
                ADDR_VIEW_W: view_w_reg <= pwdata[8:0];
                ADDR_VIEW_H: view_h_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_VIEW_W: prdata = {{(PDATA_W-9){1'b0}}, view_w_reg};
            ADDR_VIEW_H: prdata = {{(PDATA_W-9){1'b0}}, view_h_reg};
            default:     prdata = '0;
        endcase
    end

endmodule

[hw/rtl/tsb_checker.sv]
module tsb_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tsb_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import tsb_pkg::*;

    // reset starts the framebuffer sweep: no input is taken
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input accepted right after reset");

    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // anything but an in-view read returns all zero
    a_miss_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("nonzero payload on a result without read_valid");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind tile_sprite_blitter_unit tsb_checker u_tsb_checker (.*);

[tb/sv/tile_sprite_blitter_unit_test.sv]
`timescale 1ns / 100ps

module tile_sprite_blitter_unit_test;
    import tsb_pkg::*;

    localparam int TILE         = 8;
    localparam int FB_W         = 256;
    localparam int FB_H         = 256;
    localparam int DRAW_CYCLES  = TILE * TILE + 2;
    // Well above the slowest legal run (framebuffer sweep plus ~1800 items at
    // draw time plus worst gaps and stalls).
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_PRINTED  = 50;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One input transfer, field by field
    typedef struct {
        logic [1:0]        opcode;
        logic [2:0]        row_index;
        logic [15:0]       row_colors;
        logic signed [8:0] pos_x;
        logic signed [8:0] pos_y;
        logic [1:0]        palette_attr;
        logic              is_sprite;
        logic              flip_h;
        logic              flip_v;
    } blit_cmd_t;

    // One predicted output transfer
    typedef struct {
        int         seq;
        logic       read_valid;
        logic [1:0] pixel_color;
        logic [1:0] pixel_attr;
        logic       pixel_sprite;
    } pixel_result_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    tile_sprite_blitter_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow of the block state: tile, framebuffer, view registers
    // ------------------------------------------------------------------
    logic [15:0]   tile_img  [TILE];
    pixel_t        frame_img [FB_W * FB_H];
    logic [8:0]    view_w_reg;
    logic [8:0]    view_h_reg;
    pixel_result_t pending_pixels [$];

    int  cycle_count  = 0;
    int  fail_count   = 0;
    int  items_sent   = 0;
    int  results_seen = 0;
    int  op_count [4] = '{default: 0};

    // Idle control: sender gaps, receiver stalls, long receiver hold-off
    bit  gaps_on    = 1'b1;
    bit  stalls_on  = 1'b1;
    bit  offering   = 1'b0;   // mirrors the value scheduled on s_tvalid
    int  hold_req   = 0;
    int  hold_left  = 0;
    int  stall_left = 0;

    // Mostly short idles, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
        return $urandom_range(10, 48);
    endfunction

    function automatic int eff_cols();
        return (view_w_reg > FB_W) ? FB_W : int'(view_w_reg);
    endfunction

    function automatic int eff_rows();
        return (view_h_reg > FB_H) ? FB_H : int'(view_h_reg);
    endfunction

    // Works out the output transfer of one accepted item and updates the shadow
    function automatic void predict_blit(input blit_cmd_t c);
        pixel_result_t res;
        int            px, py, sx, sy, tr, tc, w, h, idx;
        logic [1:0]    color;
        pixel_t        pix;
        res     = '{default: '0};
        res.seq = items_sent;
        px      = c.pos_x;
        py      = c.pos_y;
        w       = eff_cols();
        h       = eff_rows();
        case (c.opcode)
            OP_LOAD: begin
                tile_img[c.row_index] = c.row_colors;
            end
            OP_DRAW: begin
                // texel (row,col) always lands at (py+row, px+col): clipping
                // never shifts the tile, flips only pick another texel
                for (int row = 0; row < TILE; row++) begin
                    sy = py + row;
                    tr = (c.is_sprite && c.flip_v) ? TILE - 1 - row : row;
                    if (sy < 0 || sy >= h) continue;
                    for (int col = 0; col < TILE; col++) begin
                        sx = px + col;
                        tc = (c.is_sprite && c.flip_h) ? TILE - 1 - col : col;
                        if (sx < 0 || sx >= w) continue;
                        color = tile_img[tr][2*tc +: 2];
                        idx   = sy * FB_W + sx;
                        if (!c.is_sprite) begin
                            frame_img[idx] = {1'b0, c.palette_attr, color};
                        end else if (color != 2'd0) begin
                            frame_img[idx] = {1'b1, c.palette_attr, color};
                        end else begin
                            // transparent texel: only the sprite flag is set
                            frame_img[idx][PIX_SPRITE_BIT] = 1'b1;
                        end
                    end
                end
            end
            OP_READ: begin
                if (px >= 0 && py >= 0 && px < w && py < h) begin
                    pix              = frame_img[py * FB_W + px];
                    res.read_valid   = 1'b1;
                    res.pixel_color  = pix[1:0];
                    res.pixel_attr   = pix[3:2];
                    res.pixel_sprite = pix[PIX_SPRITE_BIT];
                end
            end
            default: ;   // unused opcode: all-zero result
        endcase
        pending_pixels.push_back(res);
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_args(input blit_cmd_t c);
        logic [S_TDATA_W-1:0] d;
        d        = '0;
        d[2:0]   = c.row_index;
        d[18:3]  = c.row_colors;
        d[27:19] = c.pos_x;
        d[36:28] = c.pos_y;
        d[38:37] = c.palette_attr;
        d[39]    = c.is_sprite;
        d[40]    = c.flip_h;
        d[41]    = c.flip_v;
        return d;
    endfunction

    function automatic logic signed [8:0] to_pos(input int v);
        if (v < -128) v = -128;
        else if (v > 255) v = 255;
        return 9'(v);
    endfunction

    // Every field random over its whole range but positions (-128..255), any opcode
    function automatic blit_cmd_t noise_cmd();
        blit_cmd_t c;
        c.opcode       = 2'($urandom_range(0, 3));
        c.row_index    = 3'($urandom);
        c.row_colors   = 16'($urandom);
        c.pos_x        = to_pos(int'($urandom_range(0, 383)) - 128);
        c.pos_y        = to_pos(int'($urandom_range(0, 383)) - 128);
        c.palette_attr = 2'($urandom);
        c.is_sprite    = 1'($urandom);
        c.flip_h       = 1'($urandom);
        c.flip_v       = 1'($urandom);
        return c;
    endfunction

    function automatic blit_cmd_t noise_cmd_op(input logic [1:0] op);
        blit_cmd_t c;
        c        = noise_cmd();
        c.opcode = op;
        return c;
    endfunction

    function automatic blit_cmd_t load_cmd(input int row, input logic [15:0] colors);
        blit_cmd_t c;
        c            = '{default: '0};
        c.opcode     = OP_LOAD;
        c.row_index  = 3'(row);
        c.row_colors = colors;
        return c;
    endfunction

    function automatic blit_cmd_t draw_cmd(input int x, input int y, input logic [1:0] attr,
                                           input logic spr, input logic fh, input logic fv);
        blit_cmd_t c;
        c              = '{default: '0};
        c.opcode       = OP_DRAW;
        c.pos_x        = to_pos(x);
        c.pos_y        = to_pos(y);
        c.palette_attr = attr;
        c.is_sprite    = spr;
        c.flip_h       = fh;
        c.flip_v       = fv;
        return c;
    endfunction

    function automatic blit_cmd_t read_cmd(input int x, input int y);
        blit_cmd_t c;
        c        = '{default: '0};
        c.opcode = OP_READ;
        c.pos_x  = to_pos(x);
        c.pos_y  = to_pos(y);
        return c;
    endfunction

    // Tile rows with plenty of transparent texels
    function automatic logic [15:0] sparse_colors();
        logic [15:0] bits;
        bits = '0;
        for (int i = 0; i < TILE; i++)
            if ($urandom_range(0, 9) >= 4) bits[2*i +: 2] = 2'($urandom_range(1, 3));
        return bits;
    endfunction

    // Mostly near the view, sometimes anywhere in -128..255
    function automatic int pick_pos(input int lim);
        if ($urandom_range(0, 4) == 0) return int'($urandom_range(0, 383)) - 128;
        return int'($urandom_range(0, lim + 8)) - 8;
    endfunction

    task automatic report_mismatch(input string what, input int seq, input int got,
                                   input int want_v);
        fail_count++;
        if (fail_count <= MAX_PRINTED)
            $display("ERROR @%0d item %0d: %s got %0d expected %0d",
                     cycle_count, seq, what, got, want_v);
    endtask

    // ------------------------------------------------------------------
    // Input side: one transfer per call, predicted once accepted
    // ------------------------------------------------------------------
    task automatic send_blit(input blit_cmd_t c);
        int gap;
        gap = (gaps_on && $urandom_range(0, 1)) ? idle_len() : 0;
        if (gap > 0) begin
            if (offering) begin
                s_tvalid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(posedge aclk);
        end
        if (!offering) begin
            s_tvalid <= 1'b1;
            offering = 1'b1;
        end
        s_tuser <= c.opcode;
        s_tdata <= pack_args(c);
        do @(posedge aclk); while (!s_tready);
        predict_blit(c);
        op_count[c.opcode]++;
        items_sent++;
    endtask

    // Stop offering and wait until every result is back; block is idle then
    task automatic wait_drained();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        while (pending_pixels.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // APB: setup, access, then an idle cycle
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_VIEW_W) view_w_reg = data[8:0];
        else if (addr == ADDR_VIEW_H) view_h_reg = data[8:0];
        @(posedge aclk);
    endtask

    task automatic check_view_reg(input logic [PADDR_W-1:0] addr, input logic [8:0] want_v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[8:0] !== want_v)
            report_mismatch("register readback", int'(addr), int'(prdata[8:0]), int'(want_v));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_view(input logic [31:0] w, input logic [31:0] h);
        apb_write(ADDR_VIEW_W, w);
        apb_write(ADDR_VIEW_H, h);
        check_view_reg(ADDR_VIEW_W, view_w_reg);
        check_view_reg(ADDR_VIEW_H, view_h_reg);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls plus the long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (stalls_on && $urandom_range(0, 99) < 20) stall_left = idle_len();
        end
    end

    // Each accepted result against the oldest prediction, field by field
    always @(posedge aclk) begin : result_check
        pixel_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_pixels.size() == 0) begin
                report_mismatch("result with nothing pending", -1, int'(m_tdata), 0);
            end else begin
                want = pending_pixels.pop_front();
                if (m_tuser !== want.read_valid)
                    report_mismatch("read_valid", want.seq, int'(m_tuser),
                                    int'(want.read_valid));
                if (m_tdata[1:0] !== want.pixel_color)
                    report_mismatch("pixel_color", want.seq, int'(m_tdata[1:0]),
                                    int'(want.pixel_color));
                if (m_tdata[3:2] !== want.pixel_attr)
                    report_mismatch("pixel_attr", want.seq, int'(m_tdata[3:2]),
                                    int'(want.pixel_attr));
                if (m_tdata[4] !== want.pixel_sprite)
                    report_mismatch("pixel_sprite", want.seq, int'(m_tdata[4]),
                                    int'(want.pixel_sprite));
            end
        end
    end

    // Cycle counter doubles as the watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout: run exceeded %0d cycles", CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register defaults and reads of the cleared framebuffer at the view edges
    task automatic test_reset_defaults();
        check_view_reg(ADDR_VIEW_W, VIEW_W_RESET);
        check_view_reg(ADDR_VIEW_H, VIEW_H_RESET);
        send_blit(read_cmd(255, 239));
        send_blit(read_cmd(255, 240));   // first row below the default view
        send_blit(read_cmd(-1, 0));
    endtask

    // Tile loads with extreme patterns, both draw kinds, flips, clipping
    task automatic test_tile_draws();
        send_blit(load_cmd(0, 16'hE4E4));
        send_blit(load_cmd(1, 16'h1B1B));
        send_blit(load_cmd(2, 16'hFFFF));
        send_blit(load_cmd(3, 16'h0000));
        send_blit(load_cmd(4, 16'h5555));
        send_blit(load_cmd(5, 16'hAAAA));
        send_blit(load_cmd(6, 16'h00FF));
        send_blit(load_cmd(7, 16'hFF00));
        // background with flip bits set: flips must be ignored
        send_blit(draw_cmd(0, 0, 2'd3, 1'b0, 1'b1, 1'b1));
        send_blit(draw_cmd(4, 4, 2'd1, 1'b1, 1'b1, 1'b0));
        // clipped at top-left, both flips
        send_blit(draw_cmd(-3, -5, 2'd2, 1'b1, 1'b1, 1'b1));
        // clipped at right and bottom of the default view
        send_blit(draw_cmd(252, 236, 2'd0, 1'b0, 1'b0, 1'b0));
        send_blit(draw_cmd(-128, -128, 2'd3, 1'b1, 1'b0, 1'b0));
        send_blit(draw_cmd(255, 255, 2'd3, 1'b0, 1'b0, 1'b0));
        send_blit(noise_cmd_op(OP_UNUSED));
        send_blit(read_cmd(0, 0));
        send_blit(read_cmd(3, 2));
        send_blit(read_cmd(7, 7));
        send_blit(read_cmd(11, 11));
        send_blit(read_cmd(255, 239));
    endtask

    // Empty view, saturated view, single-pixel view; stored pixels survive
    task automatic test_view_registers();
        wait_drained();
        set_view(32'd0, 32'd0);
        send_blit(draw_cmd(0, 0, 2'd1, 1'b0, 1'b0, 1'b0));
        send_blit(read_cmd(0, 0));
        wait_drained();
        set_view(32'h0000_01FF, 32'hFFFF_FFFF);
        send_blit(read_cmd(0, 0));
        send_blit(draw_cmd(250, 250, 2'd3, 1'b1, 1'b0, 1'b1));
        send_blit(read_cmd(255, 255));
        wait_drained();
        set_view(32'd1, 32'd1);
        send_blit(read_cmd(0, 0));
        send_blit(read_cmd(1, 0));
        wait_drained();
        set_view(32'(VIEW_W_RESET), 32'(VIEW_H_RESET));
    endtask

    // Receiver holds off while fast items keep coming: the block must fill
    // up and drop s_tready, then drain cleanly once the hold is released
    task automatic test_backpressure();
        blit_cmd_t c;
        wait_drained();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        hold_req  = HOLD_CYCLES;
        for (int i = 0; i < 24; i++) begin
            c        = noise_cmd();
            c.opcode = (i % 3 == 0) ? OP_LOAD : OP_READ;
            c.pos_x  = to_pos($urandom_range(0, 15));
            c.pos_y  = to_pos($urandom_range(0, 15));
            send_blit(c);
        end
        wait_drained();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // Load a tile, draw it a few times, then read back around the last draw
    task automatic run_scene();
        blit_cmd_t c;
        int        n_rows, n_draws, n_reads, bx, by;
        n_rows = ($urandom_range(0, 99) < 70) ? TILE : $urandom_range(1, 3);
        for (int i = 0; i < n_rows; i++) begin
            c            = noise_cmd_op(OP_LOAD);
            if (n_rows == TILE) c.row_index = 3'(i);
            c.row_colors = ($urandom_range(0, 2) == 0) ? 16'($urandom) : sparse_colors();
            send_blit(c);
        end
        n_draws = $urandom_range(1, 3);
        bx      = 0;
        by      = 0;
        for (int i = 0; i < n_draws; i++) begin
            c       = noise_cmd_op(OP_DRAW);
            bx      = pick_pos(eff_cols());
            by      = pick_pos(eff_rows());
            c.pos_x = to_pos(bx);
            c.pos_y = to_pos(by);
            send_blit(c);
        end
        n_reads = $urandom_range(3, 8);
        for (int i = 0; i < n_reads; i++) begin
            c       = noise_cmd_op(OP_READ);
            c.pos_x = to_pos(bx + int'($urandom_range(0, 9)) - 1);
            c.pos_y = to_pos(by + int'($urandom_range(0, 9)) - 1);
            send_blit(c);
        end
        // a little noise: any opcode, any field
        if ($urandom_range(0, 9) < 3) send_blit(noise_cmd());
        // now and then the sender waits for every result before going on
        if ($urandom_range(0, 39) == 0) wait_drained();
    endtask

    task automatic test_random_scenes(input int n_items, input logic [8:0] w,
                                      input logic [8:0] h, input bit idle);
        int first;
        wait_drained();
        // junk in the unused upper register bits must not matter
        set_view({23'($urandom), w}, {23'($urandom), h});
        gaps_on   = idle;
        stalls_on = idle;
        first     = items_sent;
        while (items_sent - first < n_items) run_scene();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        foreach (tile_img[i]) tile_img[i] = '0;
        foreach (frame_img[i]) frame_img[i] = '0;
        view_w_reg = VIEW_W_RESET;
        view_h_reg = VIEW_H_RESET;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // first stream transfer waits out the framebuffer clear after reset
        test_reset_defaults();
        test_tile_draws();
        test_view_registers();
        test_backpressure();
        test_random_scenes(500, 9'd256, 9'd240, 1'b1);
        test_random_scenes(350, 9'd511, 9'd511, 1'b1);
        test_random_scenes(300, 9'd40, 9'd24, 1'b1);
        test_random_scenes(250, 9'd200, 9'd100, 1'b0);
        test_random_scenes(300, 9'd256, 9'd256, 1'b1);

        wait_drained();
        repeat (2 * DRAW_CYCLES) @(posedge aclk);
        if (pending_pixels.size() != 0)
            report_mismatch("results never returned", -1, pending_pixels.size(), 0);

        $display("Covered %0d transfers in (%0d loads, %0d draws, %0d reads, %0d unused op)",
                 items_sent, op_count[OP_LOAD], op_count[OP_DRAW], op_count[OP_READ],
                 op_count[OP_UNUSED]);
        $display("%0d results checked in %0d cycles; views empty, 1x1, small, default, saturated",
                 results_seen, cycle_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/tsb_pkg.sv
hw/rtl/tsb_fb_ram.sv
hw/rtl/tile_sprite_blitter_unit.sv
hw/rtl/tsb_checker.sv
tb/sv/tile_sprite_blitter_unit_test.sv
